@@ design/ppmp6_pkg.sv @@
// ----------------------------------------------------------------------------
// ppmp6_pkg
// Shared types and constants of the P6 stream parser: parser phases, result
// kinds, error codes, character codes and the result record.
// ----------------------------------------------------------------------------
package ppmp6_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_SKIP,
        PH_COMMENT,
        PH_NUMBER,
        PH_PIXELS,
        PH_DONE,
        PH_FAULT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PIXEL,
        KIND_ERROR
    } kind_t;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_MAGIC       = 3'd1;
    localparam logic [2:0] ERR_MALFORMED   = 3'd2;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd4;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // decimal fields saturate here; only this maxval is supported
    localparam logic [15:0] NUM_CAP = 16'd32768;
    localparam logic [15:0] MAXVAL  = 16'd255;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  pixel_byte;
        logic [14:0] image_width;
        logic [14:0] image_height;
        logic [2:0]  error_code;
        logic        run_last;
    } result_t;

endpackage

@@ design/ppmp6_parse_core.sv @@
// ----------------------------------------------------------------------------
// ppmp6_parse_core
// Parser state and the single-pass step logic: one byte in, up to two
// result records out (a header or pixel record, then an end-of-data error).
// ----------------------------------------------------------------------------
module ppmp6_parse_core #(
    parameter int MAX_DIM = 16384
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          byte_in,
    input  logic                eod_in,
    output ppmp6_pkg::result_t  res0,
    output ppmp6_pkg::result_t  res1,
    output logic [1:0]          res_count
);

    localparam int          ROW_W     = $clog2(3 * MAX_DIM + 1);
    localparam logic [15:0] DIM_LIMIT = 16'(MAX_DIM);

    typedef struct packed {
        ppmp6_pkg::phase_t phase;
        logic [1:0]        field_index;
        logic [15:0]       number_accum;
        logic [14:0]       saved_width;
        logic [14:0]       saved_height;
        logic [ROW_W-1:0]  row_bytes_left;
        logic [14:0]       rows_left;
    } state_t;

    state_t state_reg;
    state_t state_next;

    function automatic state_t init_state();
        state_t z;
        z       = '0;
        z.phase = ppmp6_pkg::PH_MAGIC0;
        return z;
    endfunction

    function automatic logic [ROW_W-1:0] row_bytes(input logic [14:0] w);
        logic [16:0] t;
        t = {2'b00, w} + {1'b0, w, 1'b0};
        return ROW_W'(t);
    endfunction

    function automatic ppmp6_pkg::result_t error_result(input logic [2:0] code);
        ppmp6_pkg::result_t r;
        r            = '0;
        r.kind       = ppmp6_pkg::KIND_ERROR;
        r.error_code = code;
        r.run_last   = 1'b1;
        return r;
    endfunction

    // close the number held in the accumulator
    function automatic state_t finish_number(input state_t cur,
                                             output logic emit,
                                             output ppmp6_pkg::result_t r);
        state_t      nx;
        logic [14:0] keep;
        nx   = cur;
        emit = 1'b0;
        r    = '0;
        keep = (cur.number_accum == '0 || cur.number_accum > DIM_LIMIT) ?
               '0 : cur.number_accum[14:0];
        nx.number_accum = '0;
        if (cur.field_index == 2'd0) begin
            nx.saved_width = keep;
            nx.field_index = 2'd1;
            nx.phase       = ppmp6_pkg::PH_SKIP;
        end else if (cur.field_index == 2'd1) begin
            nx.saved_height = keep;
            nx.field_index  = 2'd2;
            nx.phase        = ppmp6_pkg::PH_SKIP;
        end else if (cur.saved_width == '0 || cur.saved_height == '0 ||
                     cur.number_accum != ppmp6_pkg::MAXVAL) begin
            nx.phase = ppmp6_pkg::PH_FAULT;
            emit     = 1'b1;
            r        = error_result(ppmp6_pkg::ERR_UNSUPPORTED);
        end else begin
            nx.row_bytes_left = row_bytes(cur.saved_width);
            nx.rows_left      = cur.saved_height;
            nx.phase          = ppmp6_pkg::PH_PIXELS;
            emit              = 1'b1;
            r.kind            = ppmp6_pkg::KIND_HEADER;
            r.image_width     = cur.saved_width;
            r.image_height    = cur.saved_height;
        end
        return nx;
    endfunction

    // byte classes
    logic              is_digit;
    logic              is_ws;
    logic [3:0]        digit;
    logic [18:0]       accum_prod;
    logic [15:0]       accum_step;
    ppmp6_pkg::phase_t btw_phase;
    logic              btw_fail;

    assign is_digit   = byte_in inside {[ppmp6_pkg::CH_ZERO:ppmp6_pkg::CH_NINE]};
    assign is_ws      = (byte_in == ppmp6_pkg::CH_SPACE) ||
                        (byte_in inside {[ppmp6_pkg::CH_TAB:ppmp6_pkg::CH_CR]});
    assign digit      = 4'(byte_in - ppmp6_pkg::CH_ZERO);
    // accum * 10 + digit, saturating
    assign accum_prod = {state_reg.number_accum, 3'b000} +
                        {2'b00, state_reg.number_accum, 1'b0} + 19'(digit);
    assign accum_step = (accum_prod > 19'(ppmp6_pkg::NUM_CAP)) ?
                        ppmp6_pkg::NUM_CAP : accum_prod[15:0];

    // a byte where whitespace, a comment or a number may start
    always_comb begin
        btw_fail  = 1'b0;
        btw_phase = ppmp6_pkg::PH_SKIP;
        if (is_digit) begin
            btw_phase = ppmp6_pkg::PH_NUMBER;
        end else if (is_ws) begin
            btw_phase = ppmp6_pkg::PH_SKIP;
        end else if (byte_in == ppmp6_pkg::CH_HASH) begin
            btw_phase = ppmp6_pkg::PH_COMMENT;
        end else begin
            btw_fail = 1'b1;
        end
    end

    state_t             s;
    logic               a_emit;
    logic               b_emit;
    logic               fin_emit;
    ppmp6_pkg::result_t a_res;
    ppmp6_pkg::result_t b_res;
    ppmp6_pkg::result_t fin_res;
    logic [ROW_W-1:0]   rbl_dec;

    always_comb begin
        s        = state_reg;
        a_emit   = 1'b0;
        a_res    = '0;
        b_emit   = 1'b0;
        b_res    = '0;
        fin_emit = 1'b0;
        fin_res  = '0;
        rbl_dec  = state_reg.row_bytes_left - ROW_W'(1);

        case (state_reg.phase)
            ppmp6_pkg::PH_MAGIC0: begin
                if (byte_in == ppmp6_pkg::CH_P) begin
                    s.phase = ppmp6_pkg::PH_MAGIC1;
                end else begin
                    s.phase = ppmp6_pkg::PH_FAULT;
                    a_emit  = 1'b1;
                    a_res   = error_result(ppmp6_pkg::ERR_MAGIC);
                end
            end
            ppmp6_pkg::PH_MAGIC1: begin
                if (byte_in == ppmp6_pkg::CH_6) begin
                    s.phase = ppmp6_pkg::PH_SKIP;
                end else begin
                    s.phase = ppmp6_pkg::PH_FAULT;
                    a_emit  = 1'b1;
                    a_res   = error_result(ppmp6_pkg::ERR_MAGIC);
                end
            end
            ppmp6_pkg::PH_SKIP: begin
                if (btw_fail) begin
                    s.phase = ppmp6_pkg::PH_FAULT;
                    a_emit  = 1'b1;
                    a_res   = error_result(ppmp6_pkg::ERR_MALFORMED);
                end else begin
                    s.phase = btw_phase;
                    if (is_digit) begin
                        s.number_accum = {12'd0, digit};
                    end
                end
            end
            ppmp6_pkg::PH_COMMENT: begin
                if (byte_in == ppmp6_pkg::CH_LF) begin
                    s.phase = ppmp6_pkg::PH_SKIP;
                end
            end
            ppmp6_pkg::PH_NUMBER: begin
                if (is_digit) begin
                    s.number_accum = accum_step;
                end else begin
                    s      = finish_number(state_reg, fin_emit, fin_res);
                    a_emit = fin_emit;
                    a_res  = fin_res;
                    // width or height ended: this byte may open a comment
                    if (state_reg.field_index < 2'd2) begin
                        if (btw_fail) begin
                            s.phase = ppmp6_pkg::PH_FAULT;
                            a_emit  = 1'b1;
                            a_res   = error_result(ppmp6_pkg::ERR_MALFORMED);
                        end else begin
                            s.phase = btw_phase;
                        end
                    end
                end
            end
            ppmp6_pkg::PH_PIXELS: begin
                a_emit           = 1'b1;
                a_res            = '0;
                a_res.kind       = ppmp6_pkg::KIND_PIXEL;
                a_res.pixel_byte = byte_in;
                s.row_bytes_left = rbl_dec;
                if (rbl_dec == '0) begin
                    s.rows_left = state_reg.rows_left - 15'd1;
                    if (s.rows_left == '0) begin
                        a_res.run_last = 1'b1;
                        s.phase        = ppmp6_pkg::PH_DONE;
                    end else begin
                        s.row_bytes_left = row_bytes(state_reg.saved_width);
                    end
                end
            end
            default: begin
            end
        endcase

        if (eod_in) begin
            if (s.phase == ppmp6_pkg::PH_NUMBER) begin
                s      = finish_number(s, fin_emit, fin_res);
                a_emit = fin_emit;
                a_res  = fin_res;
            end
            if (s.phase == ppmp6_pkg::PH_MAGIC0 || s.phase == ppmp6_pkg::PH_MAGIC1) begin
                b_emit = 1'b1;
                b_res  = error_result(ppmp6_pkg::ERR_MAGIC);
            end else if (s.phase == ppmp6_pkg::PH_SKIP ||
                         s.phase == ppmp6_pkg::PH_COMMENT) begin
                b_emit = 1'b1;
                b_res  = error_result(ppmp6_pkg::ERR_MALFORMED);
            end else if (s.phase == ppmp6_pkg::PH_PIXELS) begin
                b_emit = 1'b1;
                b_res  = error_result(ppmp6_pkg::ERR_TRUNCATED);
            end
            s = init_state();
        end

        state_next = s;
        res0       = a_emit ? a_res : b_res;
        res1       = b_res;
        res_count  = {1'b0, a_emit} + {1'b0, b_emit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= init_state();
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/ppmp6_result_fifo.sv @@
// ----------------------------------------------------------------------------
// ppmp6_result_fifo
// Four-entry result queue: takes up to two records a cycle, hands out one.
// ----------------------------------------------------------------------------
module ppmp6_result_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_count,
    input  ppmp6_pkg::result_t  push0,
    input  ppmp6_pkg::result_t  push1,
    output logic                room_for_two,
    output logic                out_valid,
    input  logic                out_ready,
    output ppmp6_pkg::result_t  out_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppmp6_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_plus;
    logic             pop;

    assign wr_ptr_plus  = wr_ptr_reg + PTR_W'(1);
    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && out_ready;
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_data     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_count) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_plus] <= push1;
        end
    end

endmodule

@@ design/ppm_p6_stream_parser.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser
// Streaming parser for binary PPM (P6) files, one file byte per request.
// ----------------------------------------------------------------------------
// Input channel (s_): one file byte per request; s_end_of_data marks the
// last byte of the file and returns the parser to its start state.
// Result channel (m_): a header record (width, height), then one record per
// pixel component byte, run_last on the final one; an error record
// (run_last set) ends a bad or short file. A byte may give no record (magic,
// whitespace, comments, digits, trailing data) or two (last byte of a file
// that stops early: header or pixel record, then the truncated error).
// Path: a taken byte waits in the input register, is parsed, and its records
// are written into the four-entry result queue, whose head drives m_.
// Throughput: one byte per cycle, as the parse logic steps once for each byte
// it fires on; the queue must have room for two records for a byte to be parsed.
// Receiver stall: records pile up in the queue; once it holds more than two
// the parse stage holds its byte and s_ready drops. Nothing is lost.
// Reset: synchronous, active low; clears the parser state, the input
// register and the queue.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser #(
    parameter int MAX_DIM = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_end_of_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_pixel_byte,
    output logic [14:0] m_image_width,
    output logic [14:0] m_image_height,
    output logic [2:0]  m_error_code,
    output logic        m_run_last
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eod_reg;

    // parse stage handshake
    logic               fire;
    logic               room_for_two;
    logic [1:0]         res_count;
    logic [1:0]         push_count;
    ppmp6_pkg::result_t res0;
    ppmp6_pkg::result_t res1;
    ppmp6_pkg::result_t head;

    // the byte in the register is parsed once the queue can take two records
    assign fire       = in_valid_reg && room_for_two;
    assign s_ready    = !in_valid_reg || fire;
    assign push_count = fire ? res_count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
            in_eod_reg  <= s_end_of_data;
        end
    end

    ppmp6_parse_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .byte_in   (in_byte_reg),
        .eod_in    (in_eod_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    ppmp6_result_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_count   (push_count),
        .push0        (res0),
        .push1        (res1),
        .room_for_two (room_for_two),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_data     (head)
    );

    assign m_kind         = head.kind;
    assign m_pixel_byte   = head.pixel_byte;
    assign m_image_width  = head.image_width;
    assign m_image_height = head.image_height;
    assign m_error_code   = head.error_code;
    assign m_run_last     = head.run_last;

    // a byte held back by a full queue stays in the input register
    a_stall_keeps_byte: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_eod_reg)
    ) else $error("stalled input byte was lost");

    // a header is only reported for accepted, nonzero sizes
    a_header_sizes: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == ppmp6_pkg::KIND_HEADER |->
            m_image_width != '0 && m_image_height != '0 && m_error_code == ppmp6_pkg::ERR_NONE
    ) else $error("header record with zero size or error code");

    // every error record ends the run and carries a code
    a_error_ends_run: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == ppmp6_pkg::KIND_ERROR |->
            m_run_last && m_error_code != ppmp6_pkg::ERR_NONE
    ) else $error("error record without run_last or code");

    // the queue never gets records without a parsed byte
    a_push_needs_fire: assert property (
        @(posedge aclk) disable iff (!aresetn)
        push_count != 2'd0 |-> fire && room_for_two
    ) else $error("records pushed without a parsed byte");

endmodule
